// ===== design/ctok_pkg.sv =====
// Shared types, constants and byte-class functions of the C source tokenizer.
`default_nettype none
package ctok_pkg;

	localparam int LINE_BITS   = 24;
	localparam int COLUMN_BITS = 16;
	localparam int KIND_BITS   = 5;
	localparam int PUNCT_COUNT = 24;

	localparam logic [KIND_BITS-1:0] KIND_STRING     = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_COMMENT    = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_WORD       = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_SEPARATOR  = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_MACRO      = 5'd4;
	localparam logic [KIND_BITS-1:0] KIND_PUNCT_BASE = 5'd5;

	localparam logic [7:0] CH_HASH       = 8'h23;
	localparam logic [7:0] CH_BSLASH     = 8'h5C;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_SQUOTE     = 8'h27;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_STAR       = 8'h2A;

	// ( ) [ ] { } < > . , ; + - * : % / & ! ? = | ^ ~
	localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
		8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E,
		8'h2E, 8'h2C, 8'h3B, 8'h2B, 8'h2D, 8'h2A, 8'h3A, 8'h25,
		8'h2F, 8'h26, 8'h21, 8'h3F, 8'h3D, 8'h7C, 8'h5E, 8'h7E
	};

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_WORD   = 3'd1,
		MODE_SEP    = 3'd2,
		MODE_MACRO  = 3'd3,
		MODE_LINEC  = 3'd4,
		MODE_BLOCKC = 3'd5,
		MODE_STRING = 3'd6
	} mode_t;

	typedef struct packed {
		logic [7:0]             ch;
		logic [KIND_BITS-1:0]   token_kind;
		logic                   first_of_token;
		logic                   last_of_token;
		logic [LINE_BITS-1:0]   token_line;
		logic [COLUMN_BITS-1:0] token_column;
	} result_t;

	typedef struct packed {
		logic                 hit;
		logic [KIND_BITS-1:0] kind;
	} punct_t;

	function automatic logic is_word_byte(input logic [7:0] a);
		return (a >= 8'h30 && a <= 8'h39) || (a >= 8'h61 && a <= 8'h7A) ||
			(a >= 8'h41 && a <= 8'h5A) || a == CH_UNDERSCORE || a == CH_HASH;
	endfunction

	function automatic logic is_sep_byte(input logic [7:0] a);
		return a == CH_SPACE || a == CH_TAB || a == CH_LF || a == CH_CR;
	endfunction

	function automatic punct_t punct_lookup(input logic [7:0] a);
		punct_t r;
		r = '0;
		for (int i = 0; i < PUNCT_COUNT; i++) begin
			if (PUNCT_CHARS[i] == a) begin
				r.hit  = 1'b1;
				r.kind = KIND_PUNCT_BASE + KIND_BITS'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/ctok_ifs.sv =====
// Stream interfaces of the tokenizer: source bytes in, classified bytes out.
`default_nettype none
interface ctok_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_text;

	modport source(output valid, byte_in, end_of_text, input ready);
	modport sink(input valid, byte_in, end_of_text, output ready);
endinterface

interface ctok_res_if
	import ctok_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [7:0]             ch;
	logic [KIND_BITS-1:0]   token_kind;
	logic                   first_of_token;
	logic                   last_of_token;
	logic [LINE_BITS-1:0]   token_line;
	logic [COLUMN_BITS-1:0] token_column;

	modport source(output valid, ch, token_kind, first_of_token, last_of_token,
		token_line, token_column, input ready);
	modport sink(input valid, ch, token_kind, first_of_token, last_of_token,
		token_line, token_column, output ready);
endinterface
`default_nettype wire

// ===== design/ctok_lexer.sv =====
// Lexer state and single-pass classification of the held byte against its lookahead.
`default_nettype none
module ctok_lexer
	import ctok_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       acc,
	input  wire logic [7:0] byte_in,
	input  wire logic       end_of_text,
	output logic            push,
	output result_t         res
);

	logic [7:0]             held_byte_q;
	logic                   held_valid_q;
	mode_t                  mode_q, mode_n;
	logic [7:0]             quote_q, quote_n;
	logic                   esc_q, esc_n;
	logic                   bsl_q, bsl_n;
	logic                   star_q, star_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [COLUMN_BITS-1:0] col_q, col_n;
	logic [LINE_BITS-1:0]   sline_q, sline_n;
	logic [COLUMN_BITS-1:0] scol_q, scol_n;

	logic                 nv;
	logic                 hit;
	logic                 first;
	logic                 last;
	logic [KIND_BITS-1:0] kind;
	punct_t               pc;
	logic [7:0]           h;

	assign h  = held_byte_q;
	assign nv = !end_of_text;
	assign pc = punct_lookup(h);

	always_comb begin
		mode_n  = mode_q;
		quote_n = quote_q;
		esc_n   = esc_q;
		bsl_n   = bsl_q;
		star_n  = star_q;
		sline_n = sline_q;
		scol_n  = scol_q;
		line_n  = line_q;
		col_n   = col_q;
		hit     = 1'b1;
		first   = 1'b0;
		last    = 1'b0;
		kind    = KIND_STRING;

		if (h == CH_LF) begin
			line_n = (&line_q) ? line_q : line_q + 1'b1;
			col_n  = '0;
		end else if (h == CH_CR) begin
			col_n = '0;
		end else begin
			col_n = (&col_q) ? col_q : col_q + 1'b1;
		end

		case (mode_q)
			MODE_WORD: begin
				kind = KIND_WORD;
				last = !(nv && is_word_byte(byte_in));
			end
			MODE_SEP: begin
				kind = KIND_SEPARATOR;
				last = !(nv && is_sep_byte(byte_in));
			end
			MODE_MACRO: begin
				kind = KIND_MACRO;
				if (!is_sep_byte(h))
					bsl_n = (h == CH_BSLASH);
				last = (h == CH_LF) && !bsl_n;
			end
			MODE_LINEC: begin
				kind = KIND_COMMENT;
				last = nv && byte_in == CH_LF;
			end
			MODE_BLOCKC: begin
				kind = KIND_COMMENT;
				if (star_q)
					last = 1'b1;
				else if (h == CH_STAR && nv && byte_in == CH_SLASH)
					star_n = 1'b1;
			end
			MODE_STRING: begin
				kind = KIND_STRING;
				if (esc_q)
					esc_n = 1'b0;
				else if (h == CH_BSLASH)
					esc_n = 1'b1;
				else if (h == quote_q)
					last = 1'b1;
			end
			default: begin
				first = 1'b1;
				if (h == CH_HASH) begin
					kind   = KIND_MACRO;
					mode_n = MODE_MACRO;
					bsl_n  = 1'b0;
				end else if (h == CH_SLASH && nv && byte_in == CH_SLASH) begin
					kind   = KIND_COMMENT;
					mode_n = MODE_LINEC;
				end else if (h == CH_SLASH && nv && byte_in == CH_STAR) begin
					kind   = KIND_COMMENT;
					mode_n = MODE_BLOCKC;
					star_n = 1'b0;
				end else if (h == CH_DQUOTE || h == CH_SQUOTE) begin
					kind    = KIND_STRING;
					mode_n  = MODE_STRING;
					quote_n = h;
					esc_n   = 1'b0;
				end else if (pc.hit) begin
					kind = pc.kind;
					last = 1'b1;
				end else if (is_word_byte(h)) begin
					kind   = KIND_WORD;
					last   = !(nv && is_word_byte(byte_in));
					mode_n = MODE_WORD;
				end else if (is_sep_byte(h)) begin
					kind   = KIND_SEPARATOR;
					last   = !(nv && is_sep_byte(byte_in));
					mode_n = MODE_SEP;
				end else begin
					hit    = 1'b0;
					mode_n = MODE_IDLE;
				end
				if (hit) begin
					sline_n = line_n;
					scol_n  = col_n;
				end
			end
		endcase

		if (hit) begin
			if (!nv)
				last = 1'b1;
			if (last) begin
				mode_n = MODE_IDLE;
				star_n = 1'b0;
				esc_n  = 1'b0;
			end
		end
	end

	assign push = acc && held_valid_q && hit;

	always_comb begin
		res.ch             = h;
		res.token_kind     = kind;
		res.first_of_token = first;
		res.last_of_token  = last;
		res.token_line     = sline_n;
		res.token_column   = scol_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			mode_q       <= MODE_IDLE;
			quote_q      <= '0;
			esc_q        <= 1'b0;
			bsl_q        <= 1'b0;
			star_q       <= 1'b0;
			line_q       <= LINE_BITS'(1);
			col_q        <= '0;
			sline_q      <= '0;
			scol_q       <= '0;
		end else if (acc) begin
			if (end_of_text) begin
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
				mode_q       <= MODE_IDLE;
				quote_q      <= '0;
				esc_q        <= 1'b0;
				bsl_q        <= 1'b0;
				star_q       <= 1'b0;
				line_q       <= LINE_BITS'(1);
				col_q        <= '0;
				sline_q      <= '0;
				scol_q       <= '0;
			end else begin
				held_byte_q  <= byte_in;
				held_valid_q <= 1'b1;
				if (held_valid_q) begin
					mode_q  <= mode_n;
					quote_q <= quote_n;
					esc_q   <= esc_n;
					bsl_q   <= bsl_n;
					star_q  <= star_n;
					line_q  <= line_n;
					col_q   <= col_n;
					sline_q <= sline_n;
					scol_q  <= scol_n;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_text) |=> !held_valid_q)
		else $error("held byte survived end of text");

	assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		star_q |-> mode_q == MODE_BLOCKC)
		else $error("comment closer flag outside block comment");

	assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> mode_q == MODE_STRING)
		else $error("escape pending outside string");

endmodule
`default_nettype wire

// ===== design/ctok_out_buf.sv =====
// Two-entry result queue that decouples the lexer from a stalling receiver.
`default_nettype none
module ctok_out_buf
	import ctok_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    pop,
	output logic         full,
	output logic         not_empty,
	output result_t      head
);

	result_t    entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/c_source_tokenizer_top.sv =====
// Top level of the C source tokenizer: byte stream in, tagged lexeme bytes out.
//
// src carries one source byte per beat (byte_in) or an end beat (end_of_text = 1).
// Each byte is classified when the following beat arrives: its result is written into
// the two-entry result queue at the edge that takes that next src beat, and can leave
// on dst once it has been written and reaches the head of the queue.
// An end beat flushes the held byte as the last of its lexeme and restarts line and
// column counting; a byte outside any lexeme produces no dst beat.
// Throughput is one src beat per cycle while the queue is not full, set by the
// single-pass lexer between the held byte register and the result queue.
// src.ready drops only while both queue entries wait on a stalled dst; nothing is
// lost or repeated, and it rises again the cycle after dst takes a beat.
// Reset (arst_n low) empties the queue, drops the held byte and sets line 1, column 0.
`default_nettype none
module c_source_tokenizer_top
	import ctok_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	ctok_src_if.sink  src,
	ctok_res_if.source dst
);

	logic    acc;
	logic    push;
	logic    full;
	logic    not_empty;
	result_t res;
	result_t head;

	assign src.ready = !full;
	assign acc       = src.valid && src.ready;

	ctok_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.byte_in     (src.byte_in),
		.end_of_text (src.end_of_text),
		.push        (push),
		.res         (res)
	);

	ctok_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (dst.valid && dst.ready),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	assign dst.valid          = not_empty;
	assign dst.ch             = head.ch;
	assign dst.token_kind     = head.token_kind;
	assign dst.first_of_token = head.first_of_token;
	assign dst.last_of_token  = head.last_of_token;
	assign dst.token_line     = head.token_line;
	assign dst.token_column   = head.token_column;

endmodule
`default_nettype wire
